>>> hdl/uplink_harq_process_table_macros.svh
// Assertion macros shared by the HARQ process table modules.
`ifndef UPLINK_HARQ_PROCESS_TABLE_MACROS_SVH
`define UPLINK_HARQ_PROCESS_TABLE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define UHPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UHPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/uhpt_pkg.sv
// Shared types, codes and tables of the uplink HARQ process table.
package uhpt_pkg;

  localparam int PROC_W = 3;
  localparam int CFG_AW = 3;

  // actions
  localparam logic [2:0] ACT_ALLOC     = 3'd0;
  localparam logic [2:0] ACT_NEW_TX    = 3'd1;
  localparam logic [2:0] ACT_RETX      = 3'd2;
  localparam logic [2:0] ACT_CRC_PASS  = 3'd3;
  localparam logic [2:0] ACT_CRC_FAIL  = 3'd4;
  localparam logic [2:0] ACT_MSG3_PASS = 3'd5;
  localparam logic [2:0] ACT_RELEASE   = 3'd6;
  localparam logic [2:0] ACT_QUERY     = 3'd7;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  // register word index
  localparam logic CFG_IDX_MAX_RETX = 1'b0;

  typedef struct packed {
    logic load;   // latch a new item
    logic step;   // one busy-list search step
    logic apply;  // update table state
    logic emit;   // load the output register
  } uhpt_cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } uhpt_stat_t;

  // RV index -> redundancy version
  function automatic logic [1:0] rv_of_idx(input logic [1:0] idx);
    logic [1:0] rv;
    case (idx)
      2'd0:    rv = 2'd0;
      2'd1:    rv = 2'd2;
      2'd2:    rv = 2'd3;
      2'd3:    rv = 2'd1;
      default: rv = 2'd0;
    endcase
    return rv;
  endfunction

  // redundancy version -> RV index
  function automatic logic [1:0] idx_of_rv(input logic [1:0] rv);
    logic [1:0] idx;
    case (rv)
      2'd0:    idx = 2'd0;
      2'd1:    idx = 2'd3;
      2'd2:    idx = 2'd1;
      2'd3:    idx = 2'd2;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

>>> hdl/uhpt_ctrl.sv
// Controller state machine of the HARQ process table.
`include "uplink_harq_process_table_macros.svh"

module uhpt_ctrl
  import uhpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  uhpt_stat_t stat_i,
  output uhpt_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.load  = in_valid_i && (state_q == S_IDLE);
    cmd_o.step  = (state_q == S_SEARCH);
    cmd_o.apply = (state_q == S_APPLY);
    cmd_o.emit  = (state_q == S_EMIT) && stat_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat_i.search_done) state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `UHPT_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd_o.load, cmd_o.step, cmd_o.apply, cmd_o.emit}), "more than one datapath command")
  `UHPT_ASSERT_NEXT(a_search_to_apply, (state_q == S_SEARCH) && stat_i.search_done, state_q == S_APPLY, "search end not followed by apply")

endmodule

>>> hdl/uhpt_dp.sv
// Datapath of the HARQ process table: queues, per-process state, result register.
`include "uplink_harq_process_table_macros.svh"

module uhpt_dp
  import uhpt_pkg::*;
#(
  parameter int NUM_PROCS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  uhpt_cmd_t   cmd_i,
  output uhpt_stat_t  stat_o,
  input  logic [4:0]  max_retx_i,
  input  logic [2:0]  action_i,
  input  logic [2:0]  proc_id_i,
  input  logic [9:0]  frame_number_i,
  input  logic [7:0]  slot_number_i,
  input  logic        rv_present_i,
  input  logic [1:0]  rv_value_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  output logic [2:0]  proc_out_o,
  output logic        ndi_o,
  output logic [4:0]  remaining_tx_o,
  output logic [1:0]  redundancy_version_o,
  output logic        crc_ok_o,
  output logic        phy_rv_valid_o,
  output logic [1:0]  phy_rv_idx_o,
  output logic [3:0]  free_procs_o
);

  localparam int IDW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CW  = $clog2(NUM_PROCS + 1);
  localparam int PW  = (IDW > PROC_W) ? IDW : PROC_W;
  localparam logic [CW-1:0] NP_CNT = CW'(NUM_PROCS);
  localparam logic [PW:0]   NP_EXT = (PW + 1)'(NUM_PROCS);

  // latched item
  logic [2:0]    action_q;
  logic [PW-1:0] proc_q;
  logic [9:0]    frame_q;
  logic [7:0]    slot_q;
  logic          rv_pres_q;
  logic [1:0]    rv_val_q;

  // search
  logic [CW-1:0] idx_q;
  logic          hit_q;

  // queues
  logic [IDW-1:0] free_q [NUM_PROCS];
  logic [CW-1:0]  free_cnt_q;
  logic [IDW-1:0] busy_q [NUM_PROCS];
  logic [CW-1:0]  busy_cnt_q;

  // per-process state
  logic           ndi_q   [NUM_PROCS];
  logic [4:0]     tx_q    [NUM_PROCS];
  logic [1:0]     rvi_q   [NUM_PROCS];
  logic           crc_q   [NUM_PROCS];
  logic           prf_q   [NUM_PROCS];
  logic [1:0]     prs_q   [NUM_PROCS];
  logic [9:0]     sfrm_q  [NUM_PROCS];
  logic [7:0]     sslot_q [NUM_PROCS];

  logic [1:0]    res_status_q;
  logic          out_valid_q;

  logic [IDW-1:0] busy_entry, proc_idx, free_head;
  logic           in_list, is_time, is_rel, need_search, proc_ok;
  logic           match_time, match_id, hit_now, alloc_ok, rel_ok;

  assign busy_entry  = busy_q[idx_q[IDW-1:0]];
  assign proc_idx    = proc_q[IDW-1:0];
  assign free_head   = free_q[0];
  assign in_list     = idx_q < busy_cnt_q;
  assign is_time     = (action_q == ACT_CRC_PASS) || (action_q == ACT_CRC_FAIL);
  assign is_rel      = (action_q == ACT_RELEASE);
  assign need_search = is_time || is_rel;
  assign proc_ok     = {1'b0, proc_q} < NP_EXT;
  assign match_time  = (sfrm_q[busy_entry] == frame_q) && (sslot_q[busy_entry] == slot_q);
  assign match_id    = proc_ok && (busy_entry == proc_idx);
  assign hit_now     = need_search && in_list && (is_time ? match_time : match_id);
  assign alloc_ok    = (free_cnt_q != '0) && (busy_cnt_q < NP_CNT);
  assign rel_ok      = hit_q && (free_cnt_q < NP_CNT);

  assign stat_o.search_done = !need_search || !in_list || hit_now;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;

  // item, search key and other payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q  <= action_i;
      proc_q    <= PW'(proc_id_i);
      frame_q   <= frame_number_i;
      slot_q    <= slot_number_i;
      rv_pres_q <= rv_present_i;
      rv_val_q  <= rv_value_i;
    end else if (cmd_i.step && hit_now && is_time) begin
      proc_q <= PW'(busy_entry);
    end else if (cmd_i.apply && (action_q == ACT_ALLOC) && alloc_ok) begin
      proc_q <= PW'(free_head);
      busy_q[busy_cnt_q[IDW-1:0]] <= free_head;
      sfrm_q[free_head]  <= frame_q;
      sslot_q[free_head] <= slot_q;
    end else if (cmd_i.apply && is_rel && rel_ok) begin
      // close up the busy list over the removed entry
      for (int i = 0; i < NUM_PROCS - 1; i++) begin
        if (CW'(i) >= idx_q) busy_q[i] <= busy_q[i + 1];
      end
    end
  end

  // control and per-process state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_cnt_q   <= NP_CNT;
      busy_cnt_q   <= '0;
      res_status_q <= ST_OK;
      for (int i = 0; i < NUM_PROCS; i++) begin
        free_q[i] <= IDW'(i);
        ndi_q[i]  <= 1'b0;
        tx_q[i]   <= '0;
        rvi_q[i]  <= '0;
        crc_q[i]  <= 1'b0;
        prf_q[i]  <= 1'b0;
        prs_q[i]  <= '0;
      end
    end else if (cmd_i.load) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (hit_now) begin
        hit_q <= 1'b1;
      end else if (need_search && in_list) begin
        idx_q <= idx_q + 1'b1;
      end
    end else if (cmd_i.apply) begin
      res_status_q <= ST_OK;
      case (action_q)
        ACT_ALLOC: begin
          if (alloc_ok) begin
            for (int i = 0; i < NUM_PROCS - 1; i++) begin
              free_q[i] <= free_q[i + 1];
            end
            free_cnt_q <= free_cnt_q - 1'b1;
            busy_cnt_q <= busy_cnt_q + 1'b1;
          end else begin
            res_status_q <= ST_NO_FREE;
          end
        end
        ACT_NEW_TX: begin
          if (proc_ok) begin
            ndi_q[proc_idx] <= !ndi_q[proc_idx];
            tx_q[proc_idx]  <= max_retx_i;
            crc_q[proc_idx] <= 1'b0;
            rvi_q[proc_idx] <= '0;
            prf_q[proc_idx] <= 1'b0;
          end
        end
        ACT_RETX: begin
          if (proc_ok) begin
            if (tx_q[proc_idx] != '0) tx_q[proc_idx] <= tx_q[proc_idx] - 1'b1;
            rvi_q[proc_idx] <= rvi_q[proc_idx] + 1'b1;
            prf_q[proc_idx] <= 1'b0;
          end
        end
        ACT_CRC_PASS: begin
          if (hit_q) crc_q[proc_idx] <= 1'b1;
          else res_status_q <= ST_NO_MATCH;
        end
        ACT_CRC_FAIL: begin
          if (hit_q) begin
            prf_q[proc_idx] <= rv_pres_q;
            if (rv_pres_q) prs_q[proc_idx] <= idx_of_rv(rv_val_q);
          end else begin
            res_status_q <= ST_NO_MATCH;
          end
        end
        ACT_MSG3_PASS: begin
          if (proc_ok) begin
            crc_q[proc_idx] <= 1'b1;
            tx_q[proc_idx]  <= '0;
          end
        end
        ACT_RELEASE: begin
          if (rel_ok) begin
            tx_q[proc_idx] <= '0;
            free_q[free_cnt_q[IDW-1:0]] <= proc_idx;
            free_cnt_q <= free_cnt_q + 1'b1;
            busy_cnt_q <= busy_cnt_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o             <= res_status_q;
      free_procs_o         <= 4'(free_cnt_q);
      proc_out_o           <= '0;
      ndi_o                <= 1'b0;
      remaining_tx_o       <= '0;
      redundancy_version_o <= '0;
      crc_ok_o             <= 1'b0;
      phy_rv_valid_o       <= 1'b0;
      phy_rv_idx_o         <= '0;
      if (res_status_q == ST_OK) begin
        proc_out_o <= proc_q[PROC_W-1:0];
        if (proc_ok) begin
          ndi_o                <= ndi_q[proc_idx];
          remaining_tx_o       <= tx_q[proc_idx];
          redundancy_version_o <= rv_of_idx(rvi_q[proc_idx]);
          crc_ok_o             <= crc_q[proc_idx];
          phy_rv_valid_o       <= prf_q[proc_idx];
          phy_rv_idx_o         <= prs_q[proc_idx];
        end
      end
    end
  end

  `UHPT_ASSERT_ALWAYS(a_count_sum, free_cnt_q + busy_cnt_q == NUM_PROCS, "free and busy counts do not add up")
  `UHPT_ASSERT_ALWAYS(a_free_bound, free_cnt_q <= NP_CNT, "free count above process count")
  `UHPT_ASSERT_NEXT(a_alloc_grows, cmd_i.apply && (action_q == ACT_ALLOC) && alloc_ok, busy_cnt_q == $past(busy_cnt_q) + 1'b1, "allocate did not grow busy list")

endmodule

>>> hdl/uplink_harq_process_table.sv
// Top level of the uplink HARQ process table: register port, controller, datapath.
//
// Uplink HARQ process table. Holds NUM_PROCS processes, a FIFO of free process
// ids and a busy list kept in allocation order. Each input item is one action
// (allocate, new tx, retx, crc pass, crc fail, msg3 pass, release, query) and
// yields exactly one result item carrying the process state after the action
// and the free count. Items are handled one at a time. An item that allocates
// or addresses a process directly goes through one search, one update and one
// output step, which loads the result register. Crc pass, crc fail and release
// walk the busy list one entry per cycle in the search step, plus one more step
// when the walk runs off the end of the list without a match. Removal on release
// closes the list in the single update step. A new item is taken as soon as the
// previous one has been written into the output register, even if that result
// is still waiting for out_ready_i.
// max_retx (reset 3) sits at byte address 0 of the APB-style port; write it
// only while the table is idle. Failed allocate and failed time match report
// zeros for all process fields; an id at or above NUM_PROCS is ignored and
// echoed.
module uplink_harq_process_table
  import uhpt_pkg::*;
#(
  parameter int NUM_PROCS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // action channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [2:0]        proc_id_i,
  input  logic [9:0]        frame_number_i,
  input  logic [7:0]        slot_number_i,
  input  logic              rv_present_i,
  input  logic [1:0]        rv_value_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [2:0]        proc_out_o,
  output logic              ndi_o,
  output logic [4:0]        remaining_tx_o,
  output logic [1:0]        redundancy_version_o,
  output logic              crc_ok_o,
  output logic              phy_rv_valid_o,
  output logic [1:0]        phy_rv_idx_o,
  output logic [3:0]        free_procs_o
);

  logic [4:0] max_retx_q;
  logic       reg_hit;
  uhpt_cmd_t  cmd;
  uhpt_stat_t stat;

  // word address decode; only word 0 exists
  assign reg_hit = (paddr[CFG_AW-1] == CFG_IDX_MAX_RETX);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {27'd0, max_retx_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retx_q <= 5'd3;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_retx_q <= pwdata[4:0];
    end
  end

  uhpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  uhpt_dp #(
    .NUM_PROCS (NUM_PROCS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .max_retx_i           (max_retx_q),
    .action_i             (action_i),
    .proc_id_i            (proc_id_i),
    .frame_number_i       (frame_number_i),
    .slot_number_i        (slot_number_i),
    .rv_present_i         (rv_present_i),
    .rv_value_i           (rv_value_i),
    .out_ready_i          (out_ready_i),
    .out_valid_o          (out_valid_o),
    .status_o             (status_o),
    .proc_out_o           (proc_out_o),
    .ndi_o                (ndi_o),
    .remaining_tx_o       (remaining_tx_o),
    .redundancy_version_o (redundancy_version_o),
    .crc_ok_o             (crc_ok_o),
    .phy_rv_valid_o       (phy_rv_valid_o),
    .phy_rv_idx_o         (phy_rv_idx_o),
    .free_procs_o         (free_procs_o)
  );

endmodule

>>> test/uplink_harq_process_table_test.sv
// Testbench for the uplink HARQ process table: directed and random actions checked against a predictor.
module uplink_harq_process_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uhpt_pkg::*;

  localparam int NUM_PROCS    = 8;
  localparam int PHASE_ITEMS  = 420;        // random items per max_retx setting
  localparam int CYCLE_LIMIT  = 1_000_000;  // a run that goes past it is reported as a failure
  localparam int DRAIN_CYCLES = 4 + NUM_PROCS + 8;
  localparam logic [CFG_AW-1:0] MAX_RETX_ADDR = CFG_AW'({CFG_IDX_MAX_RETX, 2'b00});

  // RV index -> redundancy version {0,2,3,1}, PHY RV -> RV index {0,3,1,2};
  // entry k sits at bits [2k+1:2k]
  localparam logic [7:0] RV_BY_INDEX = {2'd1, 2'd3, 2'd2, 2'd0};
  localparam logic [7:0] INDEX_BY_RV = {2'd2, 2'd1, 2'd3, 2'd0};

  typedef struct packed {
    logic [2:0] act;
    logic [2:0] proc_id;
    logic [9:0] frame;
    logic [7:0] slot;
    logic       rv_present;
    logic [1:0] rv_value;
  } harq_action_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] proc_out;
    logic       ndi;
    logic [4:0] remaining_tx;
    logic [1:0] rv;
    logic       crc_ok;
    logic       phy_rv_valid;
    logic [1:0] phy_rv_idx;
    logic [3:0] free_procs;
  } harq_report_t;

  // one line of the directed table; typed rows carry their own expected result
  typedef struct packed {
    harq_action_t item;
    logic         typed;
    harq_report_t want;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block interface
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] action_i = '0;
  logic [2:0] proc_id_i = '0;
  logic [9:0] frame_number_i = '0;
  logic [7:0] slot_number_i = '0;
  logic       rv_present_i = 1'b0;
  logic [1:0] rv_value_i = '0;

  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [2:0] proc_out_o;
  logic       ndi_o;
  logic [4:0] remaining_tx_o;
  logic [1:0] redundancy_version_o;
  logic       crc_ok_o;
  logic       phy_rv_valid_o;
  logic [1:0] phy_rv_idx_o;
  logic [3:0] free_procs_o;

  uplink_harq_process_table #(
    .NUM_PROCS(NUM_PROCS)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .proc_id_i           (proc_id_i),
    .frame_number_i      (frame_number_i),
    .slot_number_i       (slot_number_i),
    .rv_present_i        (rv_present_i),
    .rv_value_i          (rv_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .proc_out_o          (proc_out_o),
    .ndi_o               (ndi_o),
    .remaining_tx_o      (remaining_tx_o),
    .redundancy_version_o(redundancy_version_o),
    .crc_ok_o            (crc_ok_o),
    .phy_rv_valid_o      (phy_rv_valid_o),
    .phy_rv_idx_o        (phy_rv_idx_o),
    .free_procs_o        (free_procs_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the process table
  // ---------------------------------------------------------------------------
  logic [4:0] retx_limit;
  logic [2:0] free_fifo  [NUM_PROCS];
  int         free_cnt;
  logic [2:0] busy_list  [NUM_PROCS];   // oldest allocation first
  int         busy_cnt;
  logic       ndi_flag   [NUM_PROCS];
  logic [4:0] tx_left    [NUM_PROCS];
  logic [1:0] rv_idx     [NUM_PROCS];
  logic       crc_seen   [NUM_PROCS];
  logic       phy_flag   [NUM_PROCS];
  logic [1:0] phy_store  [NUM_PROCS];
  logic [9:0] stamp_frame[NUM_PROCS];
  logic [7:0] stamp_slot [NUM_PROCS];

  harq_report_t pending_reports[$];
  plan_row_t    directed_plan[$];
  int           mismatches = 0;
  int           calm_left = 0;     // sender: items left in a gap-free stretch
  int           ready_hold = 0;    // receiver: cycles before the next ready decision
  int           ready_roll;
  int           cycle_count = 0;

  function automatic void reset_table();
    int i;
    retx_limit = 5'd3;
    for (i = 0; i < NUM_PROCS; i++) begin
      free_fifo[i]   = 3'(i);
      busy_list[i]   = '0;
      ndi_flag[i]    = 1'b0;
      tx_left[i]     = '0;
      rv_idx[i]      = '0;
      crc_seen[i]    = 1'b0;
      phy_flag[i]    = 1'b0;
      phy_store[i]   = '0;
      stamp_frame[i] = '0;
      stamp_slot[i]  = '0;
    end
    free_cnt = NUM_PROCS;
    busy_cnt = 0;
  endfunction

  // Result for process p after the action; failed actions zero every
  // per-process field but still report the free count.
  function automatic harq_report_t table_report(logic [1:0] st, logic [2:0] p, bit has_proc);
    harq_report_t r;
    r = '0;
    r.status = st;
    r.free_procs = 4'(free_cnt);
    if (has_proc) begin
      r.proc_out     = p;
      r.ndi          = ndi_flag[p];
      r.remaining_tx = tx_left[p];
      r.rv           = RV_BY_INDEX[{rv_idx[p], 1'b0} +: 2];
      r.crc_ok       = crc_seen[p];
      r.phy_rv_valid = phy_flag[p];
      r.phy_rv_idx   = phy_store[p];
    end
    return r;
  endfunction

  function automatic harq_report_t apply_action(harq_action_t a);
    int i;
    int pos;
    logic [2:0] p;
    pos = -1;
    p = a.proc_id;
    case (a.act)
      ACT_ALLOC: begin
        if (free_cnt == 0) return table_report(ST_NO_FREE, 3'd0, 1'b0);
        p = free_fifo[0];
        for (i = 0; i + 1 < free_cnt; i++) free_fifo[i] = free_fifo[i + 1];
        free_cnt--;
        busy_list[busy_cnt] = p;
        busy_cnt++;
        stamp_frame[p] = a.frame;
        stamp_slot[p] = a.slot;
      end
      ACT_CRC_PASS, ACT_CRC_FAIL: begin
        // oldest busy process stamped with this time wins
        for (i = 0; i < busy_cnt; i++) begin
          if (pos < 0 && stamp_frame[busy_list[i]] == a.frame &&
              stamp_slot[busy_list[i]] == a.slot) pos = i;
        end
        if (pos < 0) return table_report(ST_NO_MATCH, 3'd0, 1'b0);
        p = busy_list[pos];
        if (a.act == ACT_CRC_PASS) begin
          crc_seen[p] = 1'b1;
        end else begin
          phy_flag[p] = a.rv_present;
          if (a.rv_present) phy_store[p] = INDEX_BY_RV[{a.rv_value, 1'b0} +: 2];
        end
      end
      ACT_NEW_TX: begin
        ndi_flag[p] = ~ndi_flag[p];
        tx_left[p]  = retx_limit;
        crc_seen[p] = 1'b0;
        rv_idx[p]   = '0;
        phy_flag[p] = 1'b0;
      end
      ACT_RETX: begin
        if (tx_left[p] != '0) tx_left[p] = tx_left[p] - 5'd1;
        rv_idx[p]   = rv_idx[p] + 2'd1;
        phy_flag[p] = 1'b0;
      end
      ACT_MSG3_PASS: begin
        crc_seen[p] = 1'b1;
        tx_left[p]  = '0;
      end
      ACT_RELEASE: begin
        // a process that is not busy is left alone and just reported
        for (i = 0; i < busy_cnt; i++) begin
          if (pos < 0 && busy_list[i] == p) pos = i;
        end
        if (pos >= 0) begin
          for (i = pos; i + 1 < busy_cnt; i++) busy_list[i] = busy_list[i + 1];
          busy_cnt--;
          tx_left[p] = '0;
          free_fifo[free_cnt] = p;
          free_cnt++;
        end
      end
      default: ;  // query
    endcase
    return table_report(ST_OK, p, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic harq_action_t mk_action(logic [2:0] act, logic [2:0] id, logic [9:0] frame,
                                             logic [7:0] slot, logic rvp, logic [1:0] rvv);
    harq_action_t a;
    a = {act, id, frame, slot, rvp, rvv};
    return a;
  endfunction

  function automatic harq_report_t mk_report(logic [1:0] st, logic [2:0] p, logic [3:0] nfree);
    harq_report_t r;
    r = '0;
    r.status = st;
    r.proc_out = p;
    r.free_procs = nfree;
    return r;
  endfunction

  function automatic void add_row(harq_action_t a, logic typed, harq_report_t want);
    plan_row_t row;
    row = {a, typed, want};
    directed_plan.push_back(row);
  endfunction

  // Random action shaped by the current table: CRC times mostly hit a busy
  // process, addressed actions mostly target busy ones, and some allocations
  // reuse a tiny time pool so that several processes share a stamp.
  function automatic harq_action_t random_action();
    harq_action_t a;
    int r;
    logic [2:0] pick;
    a.proc_id    = 3'($urandom_range(0, 7));
    a.frame      = 10'($urandom_range(0, 1023));
    a.slot       = 8'($urandom_range(0, 255));
    a.rv_present = 1'($urandom_range(0, 1));
    a.rv_value   = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 18)      a.act = ACT_ALLOC;
    else if (r < 30) a.act = ACT_NEW_TX;
    else if (r < 46) a.act = ACT_RETX;
    else if (r < 56) a.act = ACT_CRC_PASS;
    else if (r < 70) a.act = ACT_CRC_FAIL;
    else if (r < 76) a.act = ACT_MSG3_PASS;
    else if (r < 90) a.act = ACT_RELEASE;
    else             a.act = ACT_QUERY;
    if (busy_cnt > 0) begin
      pick = busy_list[$urandom_range(0, busy_cnt - 1)];
      if ((a.act == ACT_CRC_PASS || a.act == ACT_CRC_FAIL) && $urandom_range(0, 4) != 0) begin
        a.frame = stamp_frame[pick];
        a.slot  = stamp_slot[pick];
      end else if (a.act != ACT_ALLOC && $urandom_range(0, 3) != 0) begin
        a.proc_id = pick;
      end
    end
    if (a.act == ACT_ALLOC && $urandom_range(0, 2) == 0) begin
      a.frame = 10'($urandom_range(0, 1));
      a.slot  = 8'($urandom_range(0, 1));
    end
    return a;
  endfunction

  // Mostly back-to-back or short gaps, sometimes long, with gap-free stretches.
  function automatic int sender_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Drive one item and hold it until accepted; the prediction is made at the
  // accepting edge. valid stays high if the next item follows with no gap.
  task automatic push_action(input harq_action_t a, input logic typed, input harq_report_t fixed);
    int gap;
    harq_report_t want;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= a.act;
    proc_id_i      <= a.proc_id;
    frame_number_i <= a.frame;
    slot_number_i  <= a.slot;
    rv_present_i   <= a.rv_present;
    rv_value_i     <= a.rv_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = apply_action(a);
    if (typed) want = fixed;
    pending_reports.push_back(want);
  endtask

  // Ends with the bus idle so that the next transfer starts cleanly.
  task automatic cfg_write_max_retx(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_RETX_ADDR;
    pwdata  <= {27'($urandom), value};  // upper bits are not part of the register
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    retx_limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_check_max_retx();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_RETX_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[4:0] !== retx_limit) begin
      $display("%0t ns: max_retx readback mismatch, expected %0d, got %0d",
               $time, retx_limit, prdata[4:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [4:0] want, logic [4:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void take_report();
    harq_report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, got status %0d proc %0d",
               $time, status_o, proc_out_o);
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("status", want.status, status_o);
    check_field("proc_out", want.proc_out, proc_out_o);
    check_field("ndi", want.ndi, ndi_o);
    check_field("remaining_tx", want.remaining_tx, remaining_tx_o);
    check_field("redundancy_version", want.rv, redundancy_version_o);
    check_field("crc_ok", want.crc_ok, crc_ok_o);
    check_field("phy_rv_valid", want.phy_rv_valid, phy_rv_valid_o);
    check_field("phy_rv_idx", want.phy_rv_idx, phy_rv_idx_o);
    check_field("free_procs", want.free_procs, free_procs_o);
  endfunction

  // Values read right after the edge are the ones the edge sampled. The ready
  // pattern mixes long open stretches, short stalls and occasional long stalls.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) take_report();
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 8) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(20, 60);
      end else if (ready_roll < 60) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 4);
      end else if (ready_roll < 92) begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("uplink_harq_process_table_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows are the ones readable at a glance: the empty
  // table, misses on an empty busy list, release of an idle process and the
  // allocate with no free process. Everything else goes to the predictor.
  // ---------------------------------------------------------------------------
  function automatic void load_directed_plan();
    harq_report_t none;
    none = '0;
    // fresh table: all state zero, every process free
    add_row(mk_action(ACT_QUERY, 3'd0, 10'd0, 8'd0, 1'b0, 2'd0), 1'b1,
            mk_report(ST_OK, 3'd0, 4'd8));
    add_row(mk_action(ACT_CRC_PASS, 3'd0, 10'd0, 8'd0, 1'b0, 2'd0), 1'b1,
            mk_report(ST_NO_MATCH, 3'd0, 4'd8));
    add_row(mk_action(ACT_CRC_FAIL, 3'd7, 10'd1023, 8'd255, 1'b1, 2'd3), 1'b1,
            mk_report(ST_NO_MATCH, 3'd0, 4'd8));
    // release of a process that was never allocated changes nothing
    add_row(mk_action(ACT_RELEASE, 3'd7, 10'd0, 8'd0, 1'b0, 2'd0), 1'b1,
            mk_report(ST_OK, 3'd7, 4'd8));
    // fill the table; processes 1 and 2 share a time stamp
    add_row(mk_action(ACT_ALLOC, 3'd0, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd7, 10'd1023, 8'd255, 1'b1, 2'd3), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd0, 10'd1023, 8'd255, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd5, 10'd512, 8'd128, 1'b1, 2'd2), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd2, 10'd341, 8'd85, 1'b0, 2'd1), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd5, 10'd682, 8'd170, 1'b1, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd1, 10'd1, 8'd1, 1'b0, 2'd2), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd6, 10'd1022, 8'd254, 1'b1, 2'd1), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd3, 10'd5, 8'd5, 1'b0, 2'd0), 1'b1,
            mk_report(ST_NO_FREE, 3'd0, 4'd0));
    // one process through new tx and retx until tx_left saturates and RV wraps
    add_row(mk_action(ACT_NEW_TX, 3'd1, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_RETX, 3'd1, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_RETX, 3'd1, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_RETX, 3'd1, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_RETX, 3'd1, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    // duplicate time: the older of the two matches, with and without a PHY RV
    add_row(mk_action(ACT_CRC_FAIL, 3'd0, 10'd1023, 8'd255, 1'b1, 2'd2), 1'b0, none);
    add_row(mk_action(ACT_CRC_FAIL, 3'd0, 10'd1023, 8'd255, 1'b0, 2'd3), 1'b0, none);
    add_row(mk_action(ACT_CRC_PASS, 3'd0, 10'd1023, 8'd255, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_MSG3_PASS, 3'd3, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    // release from the middle of the list; the other stamped process now matches
    add_row(mk_action(ACT_RELEASE, 3'd1, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_CRC_PASS, 3'd0, 10'd1023, 8'd255, 1'b0, 2'd0), 1'b0, none);
    add_row(mk_action(ACT_ALLOC, 3'd0, 10'd0, 8'd0, 1'b0, 2'd0), 1'b0, none);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table at the reset max_retx, then random
  // phases at max_retx 0, 27, 31 and a random middle value.
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    int ph;
    logic [4:0] setting;
    reset_table();
    load_directed_plan();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_check_max_retx();
    for (i = 0; i < directed_plan.size(); i++)
      push_action(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
    in_valid_i <= 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       setting = 5'd0;
        1:       setting = 5'd27;
        2:       setting = 5'd31;
        default: setting = 5'($urandom_range(1, 26));
      endcase
      wait_drained();
      cfg_write_max_retx(setting);
      cfg_check_max_retx();
      for (i = 0; i < PHASE_ITEMS; i++) push_action(random_action(), 1'b0, '0);
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("uplink_harq_process_table_test: PASS");
    end else begin
      $display("uplink_harq_process_table_test: FAIL");
    end
    $finish;
  end

endmodule
